/* src/vlqd_pkg.sv */
package vlqd_pkg;

	localparam int LEN_W            = 24;
	localparam int BYTE_W           = 8;
	localparam int GROUP_W          = 7;
	localparam int MAX_PREFIX_BYTES = 5;
	localparam int PCNT_W           = $clog2(MAX_PREFIX_BYTES + 1);
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 24;

	localparam logic [LEN_W-1:0] CFG_RESET_VAL = LEN_W'(65536);

	localparam logic [1:0] PH_PREFIX  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_ERROR   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_SMALL = 2'd1;
	localparam logic [1:0] ST_FRAMING   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RX_CAPACITY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECV_BUFFER_SIZE = 1'd1;

	typedef struct packed {
		logic [LEN_W-1:0] rx_capacity;
		logic [LEN_W-1:0] recv_buffer_size;
	} cfg_t;

endpackage

/* src/vlq_length_prefix_deframer_top.sv */
// Length-prefixed message deframer. Each message starts with a length prefix of
// 7-bit groups, most significant first, bit 7 set meaning another prefix byte
// follows (at most 5 prefix bytes). Payload bytes up to recv_buffer_size are
// passed out; the rest are dropped. The last byte of a message carries
// msg_last with status (0 ok, 1 buffer too small) and msg_len. A zero length
// ends the message at the prefix. An unterminated prefix or a length above
// rx_capacity gives one framing-error transaction (status 2), after which the
// block ignores input until reset. One byte is taken per cycle while the result
// is not stalled: a byte goes through an input register and one decode step
// into the result register, which drives out_valid. Only out_stall slows the
// block: a stalled result holds the result register and the byte behind it.
// A result that is not a delivered byte or a message end produces no output
// transaction.
module vlq_length_prefix_deframer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [vlqd_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vlqd_pkg::BYTE_W-1:0]         out_byte,
	output logic                                byte_valid,
	output logic                                msg_last,
	output logic [1:0]                          status,
	output logic [vlqd_pkg::LEN_W-1:0]          msg_len,
	input  logic                                cfg_we,
	input  logic [vlqd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vlqd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vlqd_pkg::*;

	cfg_t              cfg;
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;
	logic              in_acc;
	logic              res_valid;

	assign adv      = v_s1 && (!res_valid || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	vlqd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vlqd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adv        (adv),
		.byte_s1    (byte_s1),
		.res_take   (!out_stall),
		.res_valid  (res_valid),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.msg_last   (msg_last),
		.status     (status),
		.msg_len    (msg_len)
	);

	assign out_valid = res_valid;

endmodule

/* src/vlqd_cfg_regs.sv */
module vlqd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vlqd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vlqd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output vlqd_pkg::cfg_t                      cfg
);
	import vlqd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_capacity      <= CFG_RESET_VAL;
			cfg_q.recv_buffer_size <= CFG_RESET_VAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RX_CAPACITY:      cfg_q.rx_capacity      <= cfg_data[LEN_W-1:0];
				REG_RECV_BUFFER_SIZE: cfg_q.recv_buffer_size <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/vlqd_core.sv */
module vlqd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vlqd_pkg::cfg_t                 cfg,
	input  logic                           adv,
	input  logic [vlqd_pkg::BYTE_W-1:0]    byte_s1,
	input  logic                           res_take,
	output logic                           res_valid,
	output logic [vlqd_pkg::BYTE_W-1:0]    out_byte,
	output logic                           byte_valid,
	output logic                           msg_last,
	output logic [1:0]                     status,
	output logic [vlqd_pkg::LEN_W-1:0]     msg_len
);
	import vlqd_pkg::*;

	logic [1:0]        phase_q, phase_d;
	logic [LEN_W-1:0]  acc_q, acc_d;
	logic              ovf_q, ovf_d;
	logic [PCNT_W-1:0] pcnt_q, pcnt_d;
	logic [LEN_W-1:0]  mlen_q, mlen_d;
	logic [LEN_W-1:0]  pay_q, pay_d;

	logic [LEN_W-1:0]  acc_full;
	logic              acc_ovf;
	logic [PCNT_W-1:0] pcnt_inc;
	logic [LEN_W-1:0]  pay_inc;
	logic              deliver;

	logic              load;
	logic [BYTE_W-1:0] r_byte;
	logic              r_bv;
	logic              r_last;
	logic [1:0]        r_st;
	logic [LEN_W-1:0]  r_size;

	logic              res_v_q;
	logic [BYTE_W-1:0] byte_q;
	logic              bv_q;
	logic              last_q;
	logic [1:0]        st_q;
	logic [LEN_W-1:0]  size_q;

	assign acc_full = {acc_q[LEN_W-GROUP_W-1:0], byte_s1[GROUP_W-1:0]};
	assign acc_ovf  = ovf_q || (acc_q[LEN_W-1:LEN_W-GROUP_W] != '0);
	assign pcnt_inc = pcnt_q + PCNT_W'(1);
	assign pay_inc  = pay_q + LEN_W'(1);
	assign deliver  = pay_q < cfg.recv_buffer_size;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		pcnt_d  = pcnt_q;
		mlen_d  = mlen_q;
		pay_d   = pay_q;
		load    = 1'b0;
		r_byte  = '0;
		r_bv    = 1'b0;
		r_last  = 1'b0;
		r_st    = ST_OK;
		r_size  = '0;
		if (adv) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (!byte_s1[BYTE_W-1]) begin
						if (acc_ovf || (acc_full > cfg.rx_capacity)) begin
							phase_d = PH_ERROR;
							load    = 1'b1;
							r_last  = 1'b1;
							r_st    = ST_FRAMING;
						end else if (acc_full == '0) begin
							acc_d  = '0;
							ovf_d  = 1'b0;
							pcnt_d = '0;
							pay_d  = '0;
							load   = 1'b1;
							r_last = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
							mlen_d  = acc_full;
							pay_d   = '0;
						end
					end else if (pcnt_inc >= PCNT_W'(MAX_PREFIX_BYTES)) begin
						phase_d = PH_ERROR;
						load    = 1'b1;
						r_last  = 1'b1;
						r_st    = ST_FRAMING;
					end else begin
						acc_d  = acc_full;
						ovf_d  = acc_ovf;
						pcnt_d = pcnt_inc;
					end
				end
				PH_PAYLOAD: begin
					pay_d = pay_inc;
					if (pay_inc == mlen_q) begin
						phase_d = PH_PREFIX;
						acc_d   = '0;
						ovf_d   = 1'b0;
						pcnt_d  = '0;
						pay_d   = '0;
						load    = 1'b1;
						r_byte  = deliver ? byte_s1 : '0;
						r_bv    = deliver;
						r_last  = 1'b1;
						r_st    = (mlen_q > cfg.recv_buffer_size) ? ST_TOO_SMALL : ST_OK;
						r_size  = mlen_q;
					end else if (deliver) begin
						load   = 1'b1;
						r_byte = byte_s1;
						r_bv   = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pcnt_q  <= '0;
			mlen_q  <= '0;
			pay_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			pcnt_q  <= pcnt_d;
			mlen_q  <= mlen_d;
			pay_q   <= pay_d;
			if (load) begin
				res_v_q <= 1'b1;
			end else if (res_take) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= r_byte;
			bv_q   <= r_bv;
			last_q <= r_last;
			st_q   <= r_st;
			size_q <= r_size;
		end
	end

	assign res_valid  = res_v_q;
	assign out_byte   = byte_q;
	assign byte_valid = bv_q;
	assign msg_last   = last_q;
	assign status     = st_q;
	assign msg_len    = size_q;

endmodule

/* src/vlqd_checker.sv */
module vlqd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                byte_valid,
	input logic                                msg_last,
	input logic [1:0]                          status,
	input logic [vlqd_pkg::LEN_W-1:0]          msg_len
);
	import vlqd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output transaction dropped");

	a_mid_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !msg_last |-> byte_valid && status == ST_OK && msg_len == '0)
		else $error("mid-message transaction without delivered byte");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FRAMING |-> msg_last && !byte_valid && msg_len == '0)
		else $error("malformed framing error transaction");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && status == ST_FRAMING |=> !out_valid)
		else $error("output after framing error");

endmodule

bind vlq_length_prefix_deframer_top vlqd_checker u_vlqd_checker (.*);
